FILE: hw/rtl/taylor_sin_cos_tan_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine, cosine and tangent unit
// Concurrent checks clocked on clk; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SIN_COS_TAN_UNIT_DEFINES_SVH
`define TAYLOR_SIN_COS_TAN_UNIT_DEFINES_SVH

`ifndef SYNTH
// check a property outside reset
`define TSCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tsct assertion failed");
// check a property at every edge, reset included
`define TSCT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tsct reset assertion failed");
`else
`define TSCT_ASSERT(lbl, prop)
`define TSCT_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: hw/rtl/tsct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsct_pkg
// Types and constants shared by the sine, cosine and tangent unit.
// ----------------------------------------------------------------------------
package tsct_pkg;

  // series length default
  localparam int unsigned TSCT_TERMS = 21;

  // field widths
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned VALUE_W = 48;
  localparam int unsigned X_W     = 27;   // reduced angle magnitude, Q.24
  localparam int unsigned M_W     = 48;   // term magnitude, Q.40
  localparam int unsigned P_W     = 52;   // product before the divide
  localparam int unsigned ACC_W   = 52;   // signed Q.40 partial sums

  // constant divide: four digits of 13 bits each
  localparam int unsigned DIG_STEPS = 4;
  localparam int unsigned DIG_W     = 13;
  localparam int unsigned REM_W     = 7;
  localparam int unsigned NUM_W     = REM_W + DIG_W;
  localparam int unsigned RCP_SH    = 27;

  // tangent divider: 15 integer steps and 32 fraction steps
  localparam int unsigned QBITS   = 47;
  localparam int unsigned TAN_INT = 15;

  // 2*pi in Q8.24 and its quotient range
  localparam logic [31:0] TWO_PI_Q24 = 32'd105414357;
  localparam int unsigned RED_STEPS  = 5;     // quotient is at most 20

  localparam logic [M_W-1:0] ONE_Q40 = M_W'(64'd1 << 40);

  // operation codes
  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  localparam logic signed [VALUE_W-1:0] TAN_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] TAN_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] angle;
  } tsct_in_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic               domain_error;
  } tsct_out_t;

  // control beat through the series cells
  typedef struct packed {
    logic           valid;
    logic [1:0]     op;
    logic           xneg;
    logic [X_W-1:0] xm;
  } tsct_ctl_t;

  // beat through the tangent divider cells
  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic                neg;
    logic                sat;
    logic                czero;
    logic [VALUE_W-1:0]  rnd;
    logic [M_W-1:0]      cm;
    logic [M_W-1:0]      rem;
    logic [QBITS-1:0]    work;
  } tsct_div_t;

endpackage

FILE: hw/rtl/tsct_term_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsct_term_cell
// One Taylor term: adds m_k into the sine or cosine sum, then forms
// m_{k+1} = floor(floor(m_k * x / 2^24) / (K+1)) over a multiply stage
// and four digit stages of a constant divide.
// ----------------------------------------------------------------------------
module tsct_term_cell import tsct_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  tsct_ctl_t               ctl_in,
  input  logic [M_W-1:0]          m_in,
  input  logic signed [ACC_W-1:0] sin_in,
  input  logic signed [ACC_W-1:0] cos_in,
  output tsct_ctl_t               ctl_out,
  output logic [M_W-1:0]          m_out,
  output logic signed [ACC_W-1:0] sin_out,
  output logic signed [ACC_W-1:0] cos_out
);

  localparam int unsigned Div     = K + 1;
  localparam logic [RCP_SH:0] Rcp = (RCP_SH+1)'(((64'd1 << RCP_SH) + Div - 1) / Div);
  localparam bit Odd     = (K % 2) == 1;
  localparam bit NegBase = Odd ? (((K - 1) / 2) % 2 == 1) : ((K / 2) % 2 == 1);

  tsct_ctl_t               ctl  [DIG_STEPS+1];
  logic signed [ACC_W-1:0] sins [DIG_STEPS+1];
  logic signed [ACC_W-1:0] coss [DIG_STEPS+1];
  logic [REM_W-1:0]        rems [DIG_STEPS+1];
  logic [P_W-1:0]          work [DIG_STEPS+1];

  logic signed [ACC_W-1:0] term;
  logic                    neg_t;
  logic signed [ACC_W-1:0] sin_next;
  logic signed [ACC_W-1:0] cos_next;
  logic [50:0]             prod_hi;
  logic [50:0]             prod_lo;
  logic [P_W-1:0]          prod;

  // signed term and sum update
  always_comb begin
    term  = signed'(ACC_W'(m_in));
    neg_t = Odd ? (NegBase ^ ctl_in.xneg) : NegBase;
    sin_next = sin_in;
    cos_next = cos_in;
    if (Odd) begin
      sin_next = neg_t ? sin_in - term : sin_in + term;
    end else begin
      cos_next = neg_t ? cos_in - term : cos_in + term;
    end
  end

  // split product m * x / 2^24
  assign prod_hi = 51'(m_in[M_W-1:24]) * 51'(ctl_in.xm);
  assign prod_lo = 51'(m_in[23:0]) * 51'(ctl_in.xm);
  assign prod    = P_W'(prod_hi) + P_W'(prod_lo[50:24]);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (adv) begin
      ctl[0]  <= ctl_in;
      sins[0] <= sin_next;
      coss[0] <= cos_next;
      rems[0] <= '0;
      work[0] <= prod;
    end
  end

  // divide stages, one 13-bit digit each
  for (genvar s = 1; s <= DIG_STEPS; s++) begin : g_dig
    logic [NUM_W-1:0]  num;
    logic [47:0]       qprod;
    logic [DIG_W-1:0]  qd;
    logic [NUM_W-1:0]  back;

    assign num   = {rems[s-1], work[s-1][P_W-1 -: DIG_W]};
    assign qprod = 48'(num) * 48'(Rcp);
    assign qd    = qprod[RCP_SH +: DIG_W];
    assign back  = NUM_W'(qd) * NUM_W'(Div);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s].valid <= 1'b0;
      end else if (adv) begin
        ctl[s]  <= ctl[s-1];
        sins[s] <= sins[s-1];
        coss[s] <= coss[s-1];
        rems[s] <= REM_W'(num - back);
        work[s] <= {work[s-1][P_W-DIG_W-1:0], qd};
      end
    end
  end

  assign ctl_out = ctl[DIG_STEPS];
  assign sin_out = sins[DIG_STEPS];
  assign cos_out = coss[DIG_STEPS];
  assign m_out   = work[DIG_STEPS][M_W-1:0];

endmodule

FILE: hw/rtl/tsct_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsct_div_cell
// One restoring step of the tangent divide: shift in the next dividend bit,
// subtract the cosine magnitude when it fits, shift the quotient bit in.
// ----------------------------------------------------------------------------
module tsct_div_cell import tsct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  tsct_div_t d_in,
  output tsct_div_t d_out
);

  logic [M_W:0] trial;
  logic         fits;
  logic [M_W:0] diff;
  tsct_div_t    d_next;

  assign trial = {d_in.rem, d_in.work[QBITS-1]};
  assign fits  = trial >= {1'b0, d_in.cm};
  assign diff  = trial - {1'b0, d_in.cm};

  // form the next remainder and quotient bits
  always_comb begin
    d_next      = d_in;
    d_next.rem  = fits ? diff[M_W-1:0] : trial[M_W-1:0];
    d_next.work = {d_in.work[QBITS-2:0], fits};
  end

  // advance one quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: hw/rtl/taylor_sin_cos_tan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sin_cos_tan_unit
// Pipelined sine, cosine and tangent of a Q8.24 angle by Taylor series.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while cmd_stall is low and returns one result beat
// per beat, in order. The path is one reduction stage modulo 2*pi, a row of
// 2*SERIES_TERMS term cells of five stages each (one multiply, four divide
// digits), one tangent setup stage, 47 restoring divide cells and the output
// register. A two-entry output buffer lets a new beat enter while a finished
// result waits; cmd_stall rises only when both entries are full.
`include "taylor_sin_cos_tan_unit_defines.svh"
module taylor_sin_cos_tan_unit import tsct_pkg::*; #(
  parameter int unsigned SERIES_TERMS = TSCT_TERMS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  tsct_in_t  cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output tsct_out_t res
);

  localparam int unsigned NCells = 2 * SERIES_TERMS;

  logic      adv;
  logic      skid_valid;
  tsct_out_t skid;

  assign adv       = !skid_valid;
  assign cmd_stall = skid_valid;

  // reduce the angle modulo 2*pi, truncating toward zero
  logic [31:0] amag;
  logic [31:0] red [RED_STEPS+1];

  assign amag   = cmd.angle[31] ? 32'(-cmd.angle) : 32'(cmd.angle);
  assign red[0] = amag;
  for (genvar b = 0; b < RED_STEPS; b++) begin : g_red
    localparam logic [31:0] Sub = TWO_PI_Q24 << (RED_STEPS - 1 - b);
    assign red[b+1] = (red[b] >= Sub) ? red[b] - Sub : red[b];
  end

  tsct_ctl_t               ctl_c [NCells+1];
  logic [M_W-1:0]          m_c   [NCells+1];
  logic signed [ACC_W-1:0] sin_c [NCells+1];
  logic signed [ACC_W-1:0] cos_c [NCells+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_c[0].valid <= cmd_valid;
      ctl_c[0].op    <= cmd.op;
      ctl_c[0].xneg  <= cmd.angle[31] && (red[RED_STEPS] != 32'd0);
      ctl_c[0].xm    <= red[RED_STEPS][X_W-1:0];
    end
  end

  assign m_c[0]   = ONE_Q40;
  assign sin_c[0] = '0;
  assign cos_c[0] = '0;

  // row of series cells
  for (genvar k = 0; k < NCells; k++) begin : g_term
    tsct_term_cell #(.K(k)) u_term (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (ctl_c[k]),
      .m_in    (m_c[k]),
      .sin_in  (sin_c[k]),
      .cos_in  (cos_c[k]),
      .ctl_out (ctl_c[k+1]),
      .m_out   (m_c[k+1]),
      .sin_out (sin_c[k+1]),
      .cos_out (cos_c[k+1])
    );
  end

  // tangent setup: magnitudes, overflow check, rounding
  logic signed [ACC_W-1:0] s_fin;
  logic signed [ACC_W-1:0] c_fin;
  logic signed [ACC_W-1:0] r_sel;
  logic signed [ACC_W-1:0] r_add;
  logic [M_W-1:0]          smag;
  logic [M_W-1:0]          cmag;
  tsct_div_t               dv [QBITS+1];

  assign s_fin = sin_c[NCells];
  assign c_fin = cos_c[NCells];
  assign r_sel = (ctl_c[NCells].op == OP_COS) ? c_fin : s_fin;
  assign r_add = r_sel + ACC_W'(128);
  assign smag  = s_fin[ACC_W-1] ? M_W'(-s_fin) : M_W'(s_fin);
  assign cmag  = c_fin[ACC_W-1] ? M_W'(-c_fin) : M_W'(c_fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0].valid <= ctl_c[NCells].valid;
      dv[0].op    <= ctl_c[NCells].op;
      dv[0].neg   <= s_fin[ACC_W-1] ^ c_fin[ACC_W-1];
      dv[0].sat   <= (63'(smag) >= {cmag, 15'd0});
      dv[0].czero <= (c_fin == '0);
      dv[0].rnd   <= VALUE_W'(r_add >>> 8);
      dv[0].cm    <= cmag;
      dv[0].rem   <= M_W'(smag >> TAN_INT);
      dv[0].work  <= {smag[TAN_INT-1:0], 32'd0};
    end
  end

  // row of divide cells
  for (genvar q = 0; q < QBITS; q++) begin : g_div
    tsct_div_cell u_div (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .d_in  (dv[q]),
      .d_out (dv[q+1])
    );
  end

  // select the result
  tsct_out_t fin;
  logic      fin_valid;

  assign fin_valid = dv[QBITS].valid;

  always_comb begin
    fin.value        = '0;
    fin.domain_error = 1'b0;
    unique case (dv[QBITS].op) inside
      OP_SIN, OP_COS: begin
        fin.value = dv[QBITS].rnd;
      end
      OP_TAN: begin
        if (dv[QBITS].czero) begin
          fin.domain_error = 1'b1;
        end else if (dv[QBITS].sat) begin
          fin.value = dv[QBITS].neg ? TAN_MIN : TAN_MAX;
        end else begin
          fin.value = dv[QBITS].neg ? -signed'({1'b0, dv[QBITS].work})
                                    : signed'({1'b0, dv[QBITS].work});
        end
      end
      default: begin
        fin.value = '0;
      end
    endcase
  end

  // output register with skid entry
  logic out_free;
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        res        <= skid;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (fin_valid) begin
        res       <= fin;
        res_valid <= 1'b1;
      end else begin
        res_valid <= 1'b0;
      end
    end else if (fin_valid && adv) begin
      skid       <= fin;
      skid_valid <= 1'b1;
    end
  end

  `TSCT_ASSERT(a_skid_has_out, skid_valid |-> res_valid)
  `TSCT_ASSERT(a_skid_drains, (skid_valid && !res_stall) |=> (res_valid && !skid_valid))
  `TSCT_ASSERT_RST(a_reset_empty, $past(rst) |-> (!res_valid && !skid_valid))

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sine, cosine and tangent unit against a bit-exact predictor.
// Directed angles at the field limits and near the cosine zeros come first.
// Random beats of every operation code follow. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import tsct_pkg::*;

  localparam int unsigned N_RANDOM   = 1500;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_AT   = 700;
  localparam int unsigned TAIL_WAIT  = 300;
  localparam longint      HALF_PI_Q24 = 64'sd26353589;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  tsct_in_t  cmd;
  logic      res_valid;
  logic      res_stall;
  tsct_out_t res;

  tsct_in_t  pending_cmds[$];
  tsct_out_t expected_res[$];
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned mismatch_cnt;
  bit          drained;

  taylor_sin_cos_tan_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Q16.32 tangent from Q.40 sums, truncated toward zero and saturated
  function automatic longint tangent_q32(input longint s, input longint c);
    bit                   neg;
    longint unsigned      sm;
    longint unsigned      cm;
    longint unsigned      q;
    longint unsigned      rem;
    neg = (s < 0) != (c < 0);
    sm  = (s < 0) ? -s : s;
    cm  = (c < 0) ? -c : c;
    q   = sm / cm;
    rem = sm % cm;
    if (q >= (64'd1 << TAN_INT))
      return neg ? longint'(TAN_MIN) : longint'(TAN_MAX);
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= cm) begin
        rem = rem - cm;
        q   = q | 64'd1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // reduce the angle, sum the series, then pick the operation
  function automatic tsct_out_t trig_result(input tsct_in_t c);
    tsct_out_t       o;
    longint          a;
    longint          r;
    longint unsigned xm;
    longint unsigned mag;
    longint          sin_sum;
    longint          cos_sum;
    bit              xneg;
    bit              minus;
    a       = c.angle;
    r       = a % longint'(TWO_PI_Q24);
    xneg    = r < 0;
    xm      = xneg ? -r : r;
    mag     = 64'd1 << 40;
    sin_sum = 0;
    cos_sum = 0;
    for (int k = 0; k < 2 * TSCT_TERMS; k++) begin
      if ((k & 1) == 0) begin
        cos_sum += (((k >> 1) & 1) != 0) ? -longint'(mag) : longint'(mag);
      end else begin
        minus = (((k - 1) >> 1) & 1) != 0;
        if (xneg) minus = !minus;
        sin_sum += minus ? -longint'(mag) : longint'(mag);
      end
      mag = ((mag >> 24) * xm + (((mag & 64'hFFFFFF) * xm) >> 24)) / (k + 1);
    end
    o = '0;
    case (c.op)
      OP_SIN: o.value = 48'((sin_sum + 128) >>> 8);
      OP_COS: o.value = 48'((cos_sum + 128) >>> 8);
      OP_TAN: begin
        if (cos_sum == 0) o.domain_error = 1'b1;
        else o.value = 48'(tangent_q32(sin_sum, cos_sum));
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic bit idle_now();
    if (cycle_cnt >= 200 && cycle_cnt < 700) return 1'b0;
    return $urandom_range(0, 99) < 23;
  endfunction

  function automatic tsct_in_t make_cmd(input logic [1:0] op, input longint ang);
    tsct_in_t c;
    c.op    = op;
    c.angle = 32'(ang);
    return c;
  endfunction

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // fill the queue: directed beats, then random ones
  initial begin
    longint ang;
    logic [1:0] op;
    pending_cmds.push_back(make_cmd(OP_SIN, 0));
    pending_cmds.push_back(make_cmd(OP_COS, 0));
    pending_cmds.push_back(make_cmd(OP_TAN, 0));
    pending_cmds.push_back(make_cmd(2'd3, 64'sh7FFFFFFF));
    pending_cmds.push_back(make_cmd(OP_SIN, 64'sh7FFFFFFF));
    pending_cmds.push_back(make_cmd(OP_COS, 64'sh7FFFFFFF));
    pending_cmds.push_back(make_cmd(OP_TAN, 64'sh7FFFFFFF));
    pending_cmds.push_back(make_cmd(OP_SIN, -64'sd2147483648));
    pending_cmds.push_back(make_cmd(OP_COS, -64'sd2147483648));
    pending_cmds.push_back(make_cmd(OP_TAN, -64'sd2147483648));
    pending_cmds.push_back(make_cmd(OP_SIN, -1));
    pending_cmds.push_back(make_cmd(OP_TAN, 1));
    pending_cmds.push_back(make_cmd(OP_SIN, 105414357));
    pending_cmds.push_back(make_cmd(OP_COS, -105414357));
    pending_cmds.push_back(make_cmd(OP_TAN, 105414356));
    // tangent near the cosine zeros: overflow and zero cosine
    for (int d = -3; d <= 3; d++)
      pending_cmds.push_back(make_cmd(OP_TAN, HALF_PI_Q24 + d));
    pending_cmds.push_back(make_cmd(OP_TAN, -HALF_PI_Q24));
    pending_cmds.push_back(make_cmd(OP_TAN, 3 * HALF_PI_Q24));
    pending_cmds.push_back(make_cmd(2'd3, -1));
    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0, 1: ang = longint'($signed($urandom));
        2: ang = $signed($urandom_range(0, 32'h0FFFFFFF)) - 64'sh08000000;
        default: ang = HALF_PI_Q24 * (2 * longint'($urandom_range(0, 80)) - 79)
                       + longint'($urandom_range(0, 400)) - 200;
      endcase
      pending_cmds.push_back(make_cmd(op, ang));
    end
  end

  // driver: predict on accept, hold while stalled, idle at random
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
      sent_cnt  <= 0;
      drained   <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected_res.push_back(trig_result(cmd));
        void'(pending_cmds.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (sent_cnt == DRAIN_AT && !drained && expected_res.size() == 0)
        drained <= 1'b1;
      if (cmd_valid && cmd_stall) begin
        // hold the stalled beat
      end else if (pending_cmds.size() > 0
                   && !(sent_cnt + (cmd_valid ? 1 : 0) == DRAIN_AT && !drained)
                   && !idle_now()) begin
        cmd_valid <= 1'b1;
        cmd       <= pending_cmds[0];
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    tsct_out_t want;
    if (rst) begin
      res_stall    <= 1'b0;
      cycle_cnt    <= 0;
      mismatch_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      res_stall <= idle_now();
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected result beat: value %h err %b", res.value,
                     res.domain_error);
        end else begin
          want = expected_res.pop_front();
          if (res.value !== want.value || res.domain_error !== want.domain_error) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: expected value %h err %b, got value %h err %b",
                       want.value, want.domain_error, res.value, res.domain_error);
          end
        end
      end
      if (cycle_cnt >= CYCLE_CAP) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // wait for the drain, then report
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && expected_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: taylor_sin_cos_tan_unit.f
+incdir+hw/rtl
hw/rtl/tsct_pkg.sv
hw/rtl/tsct_term_cell.sv
hw/rtl/tsct_div_cell.sv
hw/rtl/taylor_sin_cos_tan_unit.sv
verif/testbench.sv
